@@ src/chd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chd_pkg
// Shared types, codes and helpers for the chunked HTTP body decoder.
// ----------------------------------------------------------------------------
package chd_pkg;

  localparam logic [31:0] CHUNK_LIMIT_RST = 32'h0fff_ffff;
  localparam logic [7:0]  CH_CR           = 8'h0d;
  localparam logic [7:0]  CH_LF           = 8'h0a;
  localparam logic [7:0]  CH_SP           = 8'h20;

  typedef enum logic [1:0] {
    KIND_BEGIN  = 2'd0,
    KIND_BYTE   = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_BODY   = 4'd1,
    PH_SIZE   = 4'd2,
    PH_SPACES = 4'd3,
    PH_EXT    = 4'd4,
    PH_DATA   = 4'd5,
    PH_CRLF   = 4'd6,
    PH_FINAL  = 4'd7,
    PH_END    = 4'd8,
    PH_ERROR  = 4'd9
  } phase_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic        chunked;
    logic [31:0] body_length;
    logic [7:0]  data_byte;
  } chd_item_t;

  typedef struct packed {
    logic       body_valid;
    logic [7:0] body_byte;
    logic       consumed;
    logic [3:0] phase;
    logic       finish_ok;
  } chd_result_t;

  typedef struct packed {
    phase_e      phase;
    logic [31:0] remaining;
  } chd_state_t;

  // hex digit decode: {is_hex, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

endpackage

@@ src/chd_intf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chd_intf
// Valid/ready channels for decoder input items and result items.
// ----------------------------------------------------------------------------
interface chd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        chunked;
  logic [31:0] body_length;
  logic [7:0]  data_byte;

  modport source (output valid, kind, chunked, body_length, data_byte, input ready);
  modport sink   (input valid, kind, chunked, body_length, data_byte, output ready);
endinterface

interface chd_out_if;
  logic       valid;
  logic       ready;
  logic       body_valid;
  logic [7:0] body_byte;
  logic       consumed;
  logic [3:0] phase;
  logic       finish_ok;

  modport source (output valid, body_valid, body_byte, consumed, phase, finish_ok,
                  input ready);
  modport sink   (input valid, body_valid, body_byte, consumed, phase, finish_ok,
                  output ready);
endinterface

@@ src/chd_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chd_step
// Next-state and result logic for one item against the current parse state.
// ----------------------------------------------------------------------------
module chd_step (
  input  chd_pkg::chd_state_t  cur_i,
  input  chd_pkg::chd_item_t   item_i,
  input  logic [31:0]          limit_i,
  output chd_pkg::chd_state_t  nxt_o,
  output chd_pkg::chd_result_t res_o
);
  import chd_pkg::*;

  logic [4:0]  hex;
  logic [35:0] size_acc;
  logic        size_over;
  logic        ok;
  logic [7:0]  c;
  phase_e      ext_nxt;
  chd_state_t  nxt;
  chd_result_t res;

  assign c         = item_i.data_byte;
  assign hex       = hex_decode(c);
  assign size_acc  = {cur_i.remaining, 4'h0} + {32'd0, hex[3:0]};
  assign size_over = size_acc > {4'd0, limit_i};
  assign ext_nxt   = (c == CH_LF) ? ((cur_i.remaining == 32'd0) ? PH_FINAL : PH_DATA)
                                  : PH_EXT;

  always_comb begin
    nxt = cur_i;
    res = '0;
    ok  = 1'b1;
    case (kind_e'(item_i.kind))
      KIND_BEGIN: begin
        if (item_i.chunked) begin
          nxt.phase     = PH_SIZE;
          nxt.remaining = 32'd0;
        end else begin
          nxt.phase     = PH_BODY;
          nxt.remaining = item_i.body_length;
        end
      end
      KIND_FINISH: begin
        res.finish_ok = (cur_i.phase == PH_END);
        nxt.phase     = PH_IDLE;
      end
      KIND_BYTE: begin
        res.consumed = 1'b1;
        case (cur_i.phase)
          PH_BODY: begin
            if (cur_i.remaining == 32'd0) begin
              res.consumed = 1'b0;
              nxt.phase    = PH_END;
            end else begin
              res.body_valid = 1'b1;
              res.body_byte  = c;
              nxt.remaining  = cur_i.remaining - 32'd1;
              if (cur_i.remaining == 32'd1) nxt.phase = PH_END;
            end
          end
          PH_SIZE: begin
            if (hex[4]) begin
              if (size_over) ok = 1'b0;
              else nxt.remaining = size_acc[31:0];
            end else if (c == CH_SP) begin
              nxt.phase = PH_SPACES;
            end else if (c == CH_CR || c == CH_LF) begin
              nxt.phase = ext_nxt;
            end else begin
              ok = 1'b0;
            end
          end
          PH_SPACES: begin
            if (c != CH_SP) nxt.phase = ext_nxt;
          end
          PH_EXT: begin
            nxt.phase = ext_nxt;
          end
          PH_DATA: begin
            res.body_valid = 1'b1;
            res.body_byte  = c;
            if (cur_i.remaining != 32'd0) nxt.remaining = cur_i.remaining - 32'd1;
            if (cur_i.remaining <= 32'd1) nxt.phase = PH_CRLF;
          end
          PH_CRLF: begin
            if (c == CH_LF) nxt.phase = PH_SIZE;
            else if (c != CH_CR) ok = 1'b0;
          end
          PH_FINAL: begin
            if (c == CH_LF) nxt.phase = PH_END;
            else if (c != CH_CR) ok = 1'b0;
          end
          default: ok = 1'b0;
        endcase
        if (!ok) begin
          nxt.phase      = PH_ERROR;
          res.consumed   = 1'b0;
          res.body_valid = 1'b0;
          res.body_byte  = 8'd0;
        end
      end
      default: ;
    endcase
    res.phase = nxt.phase;
  end

  assign nxt_o = nxt;
  assign res_o = res;

endmodule

@@ src/http_chunked_body_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Deframes an HTTP message body (chunked or length-delimited), one byte/item.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : items of kind begin (mode, content length), body byte, or finish.
//   out_o : one result per item: payload byte flag and value, consumed flag,
//           parse phase after the item, and finish status.
//   cfg   : cfg_we_i/cfg_wdata_i write the chunk size limit; write only while
//           no item is in flight.
// Path: an accepted item waits in the input register, and its result is
//   registered on out_o as it moves on, when out_o is not stalled.
// Throughput: one item per cycle unless out_o stalls; the input register feeds
//   the step logic straight into the result register, and parse state updates
//   as the item moves across.
// Stall: while a result waits on out_o, the input register still takes one
//   more item; in_i.ready then drops until out_o.ready frees the result slot.
// Reset: phase idle, remaining count zero, limit 0x0fffffff, both stages empty.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  chd_in_if.sink      in_i,
  chd_out_if.source   out_o
);
  import chd_pkg::*;

  logic [31:0] limit_val_q;
  logic        s1_valid_q;
  chd_item_t   s1_item_q;
  logic        out_valid_q;
  chd_result_t out_res_q;
  chd_state_t  state_q;
  chd_state_t  state_d;
  chd_result_t res_d;
  logic        adv;
  logic        in_take;

  assign adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv;
  assign in_take = in_i.valid && in_i.ready;

  chd_step u_step (
    .cur_i  (state_q),
    .item_i (s1_item_q),
    .limit_i(limit_val_q),
    .nxt_o  (state_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_val_q <= CHUNK_LIMIT_RST;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{phase: PH_IDLE, remaining: 32'd0};
    end else begin
      if (cfg_we_i) limit_val_q <= cfg_wdata_i;
      if (in_take) s1_valid_q <= 1'b1;
      else if (adv) s1_valid_q <= 1'b0;
      if (adv) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= '{kind: in_i.kind, chunked: in_i.chunked,
                     body_length: in_i.body_length, data_byte: in_i.data_byte};
    end
    if (adv) out_res_q <= res_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.body_valid = out_res_q.body_valid;
  assign out_o.body_byte  = out_res_q.body_byte;
  assign out_o.consumed   = out_res_q.consumed;
  assign out_o.phase      = out_res_q.phase;
  assign out_o.finish_ok  = out_res_q.finish_ok;

endmodule

@@ src/chd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chd_checker
// Port-level checks on the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module chd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       body_valid_i,
  input logic [7:0] body_byte_i,
  input logic       consumed_i,
  input logic [3:0] phase_i,
  input logic       finish_ok_i
);
  import chd_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(body_byte_i)
      && $stable(phase_i) && $stable(consumed_i))
    else $error("stalled result changed");

  a_body_consumed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && body_valid_i |-> consumed_i)
    else $error("payload byte not marked consumed");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !body_valid_i |-> body_byte_i == 8'd0)
    else $error("body byte nonzero without payload");

  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && finish_ok_i |-> phase_i == PH_IDLE && !consumed_i)
    else $error("finish result not idle");

  a_consumed_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && consumed_i |-> phase_i != PH_IDLE && phase_i != PH_ERROR)
    else $error("consumed byte in idle or error phase");

endmodule

bind http_chunked_body_decoder chd_checker u_chd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .body_valid_i(out_o.body_valid),
  .body_byte_i (out_o.body_byte),
  .consumed_i  (out_o.consumed),
  .phase_i     (out_o.phase),
  .finish_ok_i (out_o.finish_ok)
);
